>>> src/ita_pkg.sv
// Shared definitions for the integer to ASCII converter.
// Holds default sizes, kind codes, ASCII codes, the sequencer state type and
// the hex digit to character mapping. No dependencies.
package ita_pkg;

   // Default sizes handed to the top level parameters
   localparam int INT_WIDTH_DEF  = 32;
   localparam int PTR_DIGITS_DEF = 16;

   // Conversion kinds
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_DEC = 2'd0;
   localparam kind_type KIND_HEX = 2'd1;
   localparam kind_type KIND_PTR = 2'd2;

   // ASCII codes
   typedef logic [7:0] char_type;
   localparam char_type CHAR_MINUS = 8'h2d;
   localparam char_type CHAR_ZERO  = 8'h30;
   localparam char_type CHAR_X     = 8'h78;
   localparam char_type CHAR_A     = 8'h61;

   // Output sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_SIGN,
      ST_ZERO,
      ST_X,
      ST_DIGIT
   } state_type;

   // Map one hex or BCD digit to its lowercase ASCII character
   function automatic char_type hex_char(input logic [3:0] nib);
      char_type c;
      if (nib < 4'd10) begin
         c = CHAR_ZERO + char_type'(nib);
      end else begin
         c = CHAR_A + char_type'(nib - 4'd10);
      end
      return c;
   endfunction

endpackage

>>> src/ita_req_if.sv
// Request channel of the integer to ASCII converter: valid, ready, payload.
// Depends on ita_pkg for the kind type.
interface ita_req_if
   import ita_pkg::*;
();
   logic     valid;
   logic     ready;
   kind_type req_type;
   logic [63:0] value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

>>> src/ita_rsp_if.sv
// Response channel of the integer to ASCII converter: one character per transaction.
// Depends on ita_pkg for the character type.
interface ita_rsp_if
   import ita_pkg::*;
();
   logic     valid;
   logic     ready;
   char_type char_code;
   logic     last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

>>> src/integer_to_ascii_converter_top.sv
// Integer to ASCII converter, top level. One transaction at a time; a value is accepted
// only when the previous run is done. Decimal values pass through the bit-serial BCD converter
// and then the digit shift, which moves one nibble per cycle while the output is not stalled;
// decimal and hex output may start with a minus sign, and pointer output is prefixed with 0x.
// Synchronous active-high reset returns the sequencer to idle and drops any pending output.
module integer_to_ascii_converter_top
   import ita_pkg::*;
#(
   parameter int INT_WIDTH  = INT_WIDTH_DEF,
   parameter int PTR_DIGITS = PTR_DIGITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ita_req_if.sink   req_if,
   ita_rsp_if.source rsp_if
);
   localparam int DEC_DIGITS = (INT_WIDTH * 1233) / 4096 + 1;
   localparam int HEX_DIGITS = (INT_WIDTH + 3) / 4;
   localparam int NIB_A      = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
   localparam int NIB        = (NIB_A > PTR_DIGITS) ? NIB_A : PTR_DIGITS;
   localparam int DIG_W      = 4 * NIB;
   localparam int CNT_W      = $clog2(NIB + 1);

   state_type               state_ff, state_in;
   logic                    neg_ff, neg_in;
   logic [DIG_W-1:0]        dig_ff, dig_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   char_type                char_ff, char_in;
   logic                    last_ff, last_in;

   logic                    accept;
   logic                    out_free;
   logic [INT_WIDTH-1:0]    int_v;
   logic                    int_neg;
   logic [INT_WIDTH-1:0]    mag;
   logic                    bcd_start;
   logic                    bcd_done;
   logic [4*DEC_DIGITS-1:0] bcd;
   logic [3:0]              top_nib;
   logic                    more_zeros;
   logic                    emit;
   char_type                emit_char;
   logic                    emit_last;
   logic                    shift_dig;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   // Magnitude of the signed low word
   assign int_v   = req_if.value[INT_WIDTH-1:0];
   assign int_neg = int_v[INT_WIDTH-1];
   assign mag     = int_neg ? (~int_v + INT_WIDTH'(1)) : int_v;

   assign bcd_start = accept && (req_if.req_type == KIND_DEC);

   ita_bcd #(
      .INT_WIDTH  (INT_WIDTH),
      .DEC_DIGITS (DEC_DIGITS)
   ) u_bcd (
      .clock (clock),
      .reset (reset),
      .start (bcd_start),
      .mag   (mag),
      .done  (bcd_done),
      .bcd   (bcd)
   );

   assign top_nib    = dig_ff[DIG_W-1 -: 4];
   assign more_zeros = (top_nib == 4'd0) && (cnt_ff > CNT_W'(1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_if.req_type)
                  KIND_DEC: state_in = ST_CONV;
                  KIND_HEX: state_in = ST_SKIP;
                  KIND_PTR: state_in = ST_ZERO;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_CONV: begin
            if (bcd_done) state_in = ST_SKIP;
         end
         ST_SKIP: begin
            if (!more_zeros) state_in = neg_ff ? ST_SIGN : ST_DIGIT;
         end
         ST_SIGN: begin
            if (out_free) state_in = ST_DIGIT;
         end
         ST_ZERO: begin
            if (out_free) state_in = ST_X;
         end
         ST_X: begin
            if (out_free) state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            if (out_free && (cnt_ff == CNT_W'(1))) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Character emission and digit shift controls
   always_comb begin
      emit      = 1'b0;
      emit_char = CHAR_ZERO;
      emit_last = 1'b0;
      shift_dig = 1'b0;
      case (state_ff)
         ST_SKIP: begin
            shift_dig = more_zeros;
         end
         ST_SIGN: begin
            emit      = out_free;
            emit_char = CHAR_MINUS;
         end
         ST_ZERO: begin
            emit      = out_free;
            emit_char = CHAR_ZERO;
         end
         ST_X: begin
            emit      = out_free;
            emit_char = CHAR_X;
         end
         ST_DIGIT: begin
            emit      = out_free;
            emit_char = hex_char(top_nib);
            emit_last = (cnt_ff == CNT_W'(1));
            shift_dig = out_free;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Load the digit register left-aligned, then advance one nibble at a time
   always_comb begin
      neg_in = neg_ff;
      dig_in = dig_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         neg_in = int_neg;
         if (req_if.req_type == KIND_PTR) begin
            dig_in = DIG_W'(req_if.value[4*PTR_DIGITS-1:0]) << (4 * (NIB - PTR_DIGITS));
            cnt_in = CNT_W'(PTR_DIGITS);
         end else begin
            dig_in = DIG_W'(mag) << (4 * (NIB - HEX_DIGITS));
            cnt_in = CNT_W'(HEX_DIGITS);
         end
      end else if ((state_ff == ST_CONV) && bcd_done) begin
         dig_in = DIG_W'(bcd) << (4 * (NIB - DEC_DIGITS));
         cnt_in = CNT_W'(DEC_DIGITS);
      end else if (shift_dig) begin
         dig_in = dig_ff << 4;
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   // Hold the output register until the sink takes the transaction
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         char_in      = emit_char;
         last_in      = emit_last;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff  <= neg_in;
      dig_ff  <= dig_in;
      cnt_ff  <= cnt_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.char_code = char_ff;
   assign rsp_if.last      = last_ff;

endmodule

>>> src/ita_bcd.sv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Depends on ita_pkg for the default of INT_WIDTH.
module ita_bcd
   import ita_pkg::*;
#(
   parameter int INT_WIDTH  = INT_WIDTH_DEF,
   parameter int DEC_DIGITS = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [INT_WIDTH-1:0]    mag,
   output logic                    done,
   output logic [4*DEC_DIGITS-1:0] bcd
);
   localparam int CNT_W = $clog2(INT_WIDTH + 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [INT_WIDTH-1:0]    shift_ff, shift_in;
   logic [4*DEC_DIGITS-1:0] bcd_ff, bcd_in;
   logic [4*DEC_DIGITS-1:0] adj;

   // Add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int d = 0; d < DEC_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   // Load on start, then shift one magnitude bit into the BCD word per cycle
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(INT_WIDTH);
         shift_in = mag;
         bcd_in   = '0;
      end else if (busy_ff) begin
         bcd_in   = {adj[4*DEC_DIGITS-2:0], shift_ff[INT_WIDTH-1]};
         shift_in = shift_ff << 1;
         cnt_in   = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule
